// ===== hw/rtl/asrd_pkg.sv =====
// Package for the analog stick radial deadzone block.
// Widths, register indexes, reset values and scaling constants.
// No dependencies; every other file in hw/rtl takes names from here.
package asrd_pkg;

    // Full deflection is 2**LEVEL_BITS
    localparam int LEVEL_BITS     = 15;
    localparam int LEVEL_W        = 16;
    localparam int GAIN_W         = 10;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int RADIUS_W       = 8;
    localparam int INVERT_W       = 2;
    localparam int COUNT_W        = 8;

    localparam int PROD_W   = LEVEL_W + GAIN_W;
    localparam int SCALED_W = PROD_W + COUNT_W;
    localparam int SHIFT    = LEVEL_BITS + GAIN_FRAC_BITS;
    localparam int SQ_W     = 2 * COUNT_W;
    localparam int SUM_W    = SQ_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] CENTRE    = COUNT_W'(127);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MODE     = 2'd2;

    localparam logic [GAIN_W-1:0]   AXIS_GAIN_RST       = GAIN_W'(340);
    localparam logic [RADIUS_W-1:0] DEADZONE_RADIUS_RST = '0;
    localparam logic [INVERT_W-1:0] INVERT_MODE_RST     = '0;

    // Direction slots within one beat
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;
    localparam int NUM_DIRS  = 4;

    typedef logic [COUNT_W-1:0] t_count;

endpackage

// ===== hw/rtl/asrd_if.sv =====
// Valid/ready channel interfaces for the analog stick radial deadzone block:
// level input, stick output and configuration write channel.
// Depends on asrd_pkg for field widths.
interface asrd_in_if;
    logic                         valid;
    logic                         ready;
    logic [asrd_pkg::LEVEL_W-1:0] up_level;
    logic [asrd_pkg::LEVEL_W-1:0] down_level;
    logic [asrd_pkg::LEVEL_W-1:0] left_level;
    logic [asrd_pkg::LEVEL_W-1:0] right_level;

    modport source (output valid, up_level, down_level, left_level, right_level,
                    input ready);
    modport sink   (input valid, up_level, down_level, left_level, right_level,
                    output ready);
endinterface

interface asrd_out_if;
    logic                         valid;
    logic                         ready;
    logic [asrd_pkg::COUNT_W-1:0] stick_x;
    logic [asrd_pkg::COUNT_W-1:0] stick_y;

    modport source (output valid, stick_x, stick_y, input ready);
    modport sink   (input valid, stick_x, stick_y, output ready);
endinterface

interface asrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [asrd_pkg::CFG_IDX_W-1:0]  idx;
    logic [asrd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

// ===== hw/rtl/analog_stick_radial_deadzone.sv =====
// Analog stick radial deadzone: four direction levels in, two centred bytes out.
// Depends on asrd_pkg and the channel interfaces in asrd_if.sv.
//
// Four-stage pipeline taking one beat per cycle while the output is not
// stalled. An accepted beat moves through stages 1 to 4 in order and is
// offered on the output from stage 4. Stage 1 multiplies each level by the
// gain, stage 2 scales by 255, shifts and clamps to a count, stage 3 applies
// the invert swaps, merges each axis into a byte and squares the magnitudes,
// stage 4 compares against the squared radius and holds the result. Each stage
// has its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles close up and a stalled output holds without loss. The
// configuration channel is always ready; registers must only be written while
// the pipeline is empty.
module analog_stick_radial_deadzone (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asrd_cfg_if.sink    i_cfg,
    asrd_in_if.sink     i_in,
    asrd_out_if.source  o_out
);

    // Configuration registers
    logic [asrd_pkg::GAIN_W-1:0]   r_axis_gain;
    logic [asrd_pkg::RADIUS_W-1:0] r_deadzone_radius;
    logic [asrd_pkg::INVERT_W-1:0] r_invert_mode;

    // Pipeline registers
    logic                         r_v1, r_v2, r_v3, r_v4;
    logic [asrd_pkg::PROD_W-1:0]  r_prod [asrd_pkg::NUM_DIRS];
    asrd_pkg::t_count             r_cnt  [asrd_pkg::NUM_DIRS];
    asrd_pkg::t_count             r_bx, r_by;
    logic [asrd_pkg::SQ_W-1:0]    r_sqx, r_sqy, r_r2;
    logic                         r_dz_en;
    asrd_pkg::t_count             r_stick_x, r_stick_y;

    logic rdy1, rdy2, rdy3, rdy4;

    logic [asrd_pkg::PROD_W-1:0]  n_prod [asrd_pkg::NUM_DIRS];
    asrd_pkg::t_count             n_cnt  [asrd_pkg::NUM_DIRS];
    asrd_pkg::t_count             n_bx, n_by;
    logic [asrd_pkg::SQ_W-1:0]    n_sqx, n_sqy, n_r2;
    asrd_pkg::t_count             n_stick_x, n_stick_y;

    // Ready ripples back: a stage takes a beat when empty or when its beat moves on
    assign rdy4 = !r_v4 || o_out.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_in.ready  = rdy1;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid   = r_v4;
    assign o_out.stick_x = r_stick_x;
    assign o_out.stick_y = r_stick_y;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_gain       <= asrd_pkg::AXIS_GAIN_RST;
            r_deadzone_radius <= asrd_pkg::DEADZONE_RADIUS_RST;
            r_invert_mode     <= asrd_pkg::INVERT_MODE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                asrd_pkg::REG_AXIS_GAIN: begin
                    r_axis_gain <= i_cfg.data[asrd_pkg::GAIN_W-1:0];
                end
                asrd_pkg::REG_DEADZONE_RADIUS: begin
                    r_deadzone_radius <= i_cfg.data[asrd_pkg::RADIUS_W-1:0];
                end
                asrd_pkg::REG_INVERT_MODE: begin
                    r_invert_mode <= i_cfg.data[asrd_pkg::INVERT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: level * gain
    always_comb begin
        n_prod[asrd_pkg::DIR_UP]    = asrd_pkg::PROD_W'(i_in.up_level)
                                    * asrd_pkg::PROD_W'(r_axis_gain);
        n_prod[asrd_pkg::DIR_DOWN]  = asrd_pkg::PROD_W'(i_in.down_level)
                                    * asrd_pkg::PROD_W'(r_axis_gain);
        n_prod[asrd_pkg::DIR_LEFT]  = asrd_pkg::PROD_W'(i_in.left_level)
                                    * asrd_pkg::PROD_W'(r_axis_gain);
        n_prod[asrd_pkg::DIR_RIGHT] = asrd_pkg::PROD_W'(i_in.right_level)
                                    * asrd_pkg::PROD_W'(r_axis_gain);
    end

    // Stage 2: *255 as shift-subtract, drop the fraction, clamp
    always_comb begin
        logic [asrd_pkg::SCALED_W-1:0] scaled;
        logic [asrd_pkg::SCALED_W-1:0] shifted;
        for (int k = 0; k < asrd_pkg::NUM_DIRS; k++) begin
            scaled  = (asrd_pkg::SCALED_W'(r_prod[k]) << asrd_pkg::COUNT_W)
                    - asrd_pkg::SCALED_W'(r_prod[k]);
            shifted = scaled >> asrd_pkg::SHIFT;
            if (|shifted[asrd_pkg::SCALED_W-1:asrd_pkg::COUNT_W]) begin
                n_cnt[k] = asrd_pkg::COUNT_MAX;
            end else begin
                n_cnt[k] = shifted[asrd_pkg::COUNT_W-1:0];
            end
        end
    end

    // Stage 3: swaps, axis merge, squares
    always_comb begin
        asrd_pkg::t_count px, nx, py, ny, sx, sy;
        px = r_invert_mode[0] ? r_cnt[asrd_pkg::DIR_LEFT]  : r_cnt[asrd_pkg::DIR_RIGHT];
        nx = r_invert_mode[0] ? r_cnt[asrd_pkg::DIR_RIGHT] : r_cnt[asrd_pkg::DIR_LEFT];
        py = r_invert_mode[1] ? r_cnt[asrd_pkg::DIR_UP]    : r_cnt[asrd_pkg::DIR_DOWN];
        ny = r_invert_mode[1] ? r_cnt[asrd_pkg::DIR_DOWN]  : r_cnt[asrd_pkg::DIR_UP];

        // positive side wins when both are deflected
        sx = (px != '0) ? px : nx;
        sy = (py != '0) ? py : ny;

        n_bx = (px != '0)
             ? asrd_pkg::CENTRE
               + asrd_pkg::COUNT_W'(((asrd_pkg::COUNT_W + 1)'(px) + 1'b1) >> 1)
             : asrd_pkg::CENTRE - (nx >> 1);
        n_by = (py != '0)
             ? asrd_pkg::CENTRE
               + asrd_pkg::COUNT_W'(((asrd_pkg::COUNT_W + 1)'(py) + 1'b1) >> 1)
             : asrd_pkg::CENTRE - (ny >> 1);

        n_sqx = asrd_pkg::SQ_W'(sx) * asrd_pkg::SQ_W'(sx);
        n_sqy = asrd_pkg::SQ_W'(sy) * asrd_pkg::SQ_W'(sy);
        n_r2  = asrd_pkg::SQ_W'(r_deadzone_radius) * asrd_pkg::SQ_W'(r_deadzone_radius);
    end

    // Stage 4: inside the circle (boundary included) snaps to centre
    always_comb begin
        logic [asrd_pkg::SUM_W-1:0] dist2;
        dist2 = asrd_pkg::SUM_W'(r_sqx) + asrd_pkg::SUM_W'(r_sqy);
        if (r_dz_en && (dist2 <= asrd_pkg::SUM_W'(r_r2))) begin
            n_stick_x = asrd_pkg::CENTRE;
            n_stick_y = asrd_pkg::CENTRE;
        end else begin
            n_stick_x = r_bx;
            n_stick_y = r_by;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in.valid) begin
            r_prod <= n_prod;
        end
        if (rdy2 && r_v1) begin
            r_cnt <= n_cnt;
        end
        if (rdy3 && r_v2) begin
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_sqx   <= n_sqx;
            r_sqy   <= n_sqy;
            r_r2    <= n_r2;
            r_dz_en <= (r_deadzone_radius != '0);
        end
        if (rdy4 && r_v3) begin
            r_stick_x <= n_stick_x;
            r_stick_y <= n_stick_y;
        end
    end

endmodule

// ===== hw/rtl/asrd_chk.sv =====
// Port-level checker for the analog stick radial deadzone block, with its bind.
// Depends on asrd_pkg for widths; attaches to analog_stick_radial_deadzone.
module asrd_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [asrd_pkg::COUNT_W-1:0] i_stick_x,
    input logic [asrd_pkg::COUNT_W-1:0] i_stick_y
);

    // Synchronous reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat valid straight after reset");

    // Empty output stage means every stage can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no output beat pending");

    // Sink taking beats must never back-pressure the input
    a_ready_follows_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output sink is ready");

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_stick_x) && $stable(i_stick_y))
        else $error("stalled output beat dropped or changed");

endmodule

bind analog_stick_radial_deadzone asrd_chk u_asrd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_stick_x   (o_out.stick_x),
    .i_stick_y   (o_out.stick_y)
);

// ===== tb/analog_stick_radial_deadzone_test.sv =====
// Self-checking testbench for analog_stick_radial_deadzone: random and directed stick levels,
// predicted stick bytes compared beat by beat against the block's output channel.
// Depends on asrd_pkg and the channel interfaces in asrd_if.sv.
module analog_stick_radial_deadzone_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asrd_pkg::*;

    // Bit positions within invert_mode
    localparam int INV_SWAP_X = 0;
    localparam int INV_SWAP_Y = 1;

    typedef struct packed {
        logic [LEVEL_W-1:0] up_lvl;
        logic [LEVEL_W-1:0] down_lvl;
        logic [LEVEL_W-1:0] left_lvl;
        logic [LEVEL_W-1:0] right_lvl;
    } levels_t;

    typedef struct packed {
        t_count x;
        t_count y;
    } stick_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    asrd_cfg_if cfg_ch();
    asrd_in_if  in_ch();
    asrd_out_if out_ch();

    analog_stick_radial_deadzone DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Register copies as seen by the block, updated on accepted config beats
    logic [GAIN_W-1:0]   model_gain   = AXIS_GAIN_RST;
    logic [RADIUS_W-1:0] model_radius = DEADZONE_RADIUS_RST;
    logic [INVERT_W-1:0] model_invert = INVERT_MODE_RST;

    // Settings of the current phase, used to shape stimulus
    int unsigned plan_gain   = 340;
    int unsigned plan_radius = 0;

    levels_t level_queue[$];
    stick_t  stick_expect[$];
    int      mismatch_count = 0;

    logic        in_taken = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    levels_t     cur_levels;

    rx_mode_e    rx_mode = RX_FREE;
    int unsigned rx_mode_left = 0;
    int unsigned rx_hold_len = 0;
    int unsigned rx_hold_left = 0;

    function automatic t_count level_count(logic [LEVEL_W-1:0] lvl, logic [GAIN_W-1:0] gain);
        logic [SCALED_W-1:0] scaled;
        scaled = SCALED_W'(lvl) * SCALED_W'(gain) * SCALED_W'(COUNT_MAX);
        scaled = scaled >> SHIFT;
        return (scaled > SCALED_W'(COUNT_MAX)) ? COUNT_MAX : t_count'(scaled);
    endfunction

    function automatic t_count merge_byte(t_count pos, t_count neg);
        if (pos != '0)
            return CENTRE + t_count'((9'(pos) + 9'd1) >> 1);
        return CENTRE - (neg >> 1);
    endfunction

    function automatic stick_t predict_stick(levels_t lv, logic [GAIN_W-1:0] gain,
                                             logic [RADIUS_W-1:0] radius,
                                             logic [INVERT_W-1:0] invert);
        t_count c_up, c_dn, c_lf, c_rt, px, nx, py, ny, sx, sy;
        logic [SUM_W-1:0] dist_sq;
        logic [SQ_W-1:0]  rad_sq;
        stick_t           res;
        c_up = level_count(lv.up_lvl, gain);
        c_dn = level_count(lv.down_lvl, gain);
        c_lf = level_count(lv.left_lvl, gain);
        c_rt = level_count(lv.right_lvl, gain);
        px = invert[INV_SWAP_X] ? c_lf : c_rt;
        nx = invert[INV_SWAP_X] ? c_rt : c_lf;
        py = invert[INV_SWAP_Y] ? c_up : c_dn;
        ny = invert[INV_SWAP_Y] ? c_dn : c_up;
        res.x = merge_byte(px, nx);
        res.y = merge_byte(py, ny);
        if (radius != '0) begin
            // positive side wins the magnitude too
            sx = (px != '0) ? px : nx;
            sy = (py != '0) ? py : ny;
            dist_sq = SUM_W'(sx) * SUM_W'(sx) + SUM_W'(sy) * SUM_W'(sy);
            rad_sq  = SQ_W'(radius) * SQ_W'(radius);
            if (dist_sq <= SUM_W'(rad_sq))
                res = '{x: CENTRE, y: CENTRE};
        end
        return res;
    endfunction

    // Smallest level that reaches the given count; all ones when out of reach
    function automatic logic [LEVEL_W-1:0] level_for_count(int unsigned cnt, int unsigned gain);
        longint unsigned step, lvl;
        step = 64'(gain) * 64'd255;
        if (step == 0)
            return '1;
        lvl = ((64'(cnt) << SHIFT) + step - 1) / step;
        return (lvl > 64'd65535) ? '1 : LEVEL_W'(lvl);
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_level(int unsigned gain, int unsigned radius);
        logic [LEVEL_W-1:0] band_top;
        band_top = level_for_count(radius + 3, gain);
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3:    return LEVEL_W'($urandom_range(0, band_top));
            4, 5:    return LEVEL_W'($urandom_range(0, 32768));
            6:       return LEVEL_W'($urandom);
            7: begin
                case ($urandom_range(0, 2))
                    0:       return LEVEL_W'(32767);
                    1:       return LEVEL_W'(32768);
                    default: return '1;
                endcase
            end
            8:       return LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1);
            default: return ~(LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1));
        endcase
    endfunction

    task automatic add_levels(int unsigned up, int unsigned dn, int unsigned lf,
                              int unsigned rt);
        level_queue.push_back('{LEVEL_W'(up), LEVEL_W'(dn), LEVEL_W'(lf), LEVEL_W'(rt)});
    endtask

    task automatic queue_random(int unsigned n);
        levels_t lv;
        repeat (n) begin
            lv.up_lvl    = rand_level(plan_gain, plan_radius);
            lv.down_lvl  = rand_level(plan_gain, plan_radius);
            lv.left_lvl  = rand_level(plan_gain, plan_radius);
            lv.right_lvl = rand_level(plan_gain, plan_radius);
            // a real stick seldom reads both ways on one axis
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 1)) lv.up_lvl = '0;
                else lv.down_lvl = '0;
                if ($urandom_range(0, 1)) lv.left_lvl = '0;
                else lv.right_lvl = '0;
            end
            level_queue.push_back(lv);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_settings(int unsigned gain, int unsigned radius, int unsigned invert);
        plan_gain   = gain;
        plan_radius = radius;
        write_reg(REG_AXIS_GAIN, gain);
        write_reg(REG_DEADZONE_RADIUS, radius);
        write_reg(REG_INVERT_MODE, invert);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sampled at the rising edge, where queue and valid are stable
    task automatic wait_drained();
        while (level_queue.size() != 0 || in_ch.valid || stick_expect.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Input driver: bursts of beats separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (level_queue.size() != 0) begin
                cur_levels = level_queue.pop_front();
                in_ch.up_level    <= cur_levels.up_lvl;
                in_ch.down_level  <= cur_levels.down_lvl;
                in_ch.left_level  <= cur_levels.left_lvl;
                in_ch.right_level <= cur_levels.right_lvl;
                in_ch.valid       <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output receiver: stall pattern changes every so often, plus a long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_e'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   out_ch.ready <= 1'b1;
                RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   out_ch.ready <= ~out_ch.ready;
            endcase
        end
    end

    // Monitor: register writes, accepted input beats and result beats
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.idx)
                    REG_AXIS_GAIN:       model_gain   = cfg_ch.data[GAIN_W-1:0];
                    REG_DEADZONE_RADIUS: model_radius = cfg_ch.data[RADIUS_W-1:0];
                    REG_INVERT_MODE:     model_invert = cfg_ch.data[INVERT_W-1:0];
                    default: ;
                endcase
            end
            if (in_taken)
                stick_expect.push_back(predict_stick('{in_ch.up_level, in_ch.down_level,
                                                       in_ch.left_level, in_ch.right_level},
                                                     model_gain, model_radius,
                                                     model_invert));
            if (out_ch.valid && out_ch.ready) begin
                if (stick_expect.size() == 0) begin
                    $error("result beat with nothing expected: stick_x %0d stick_y %0d",
                           out_ch.stick_x, out_ch.stick_y);
                    mismatch_count++;
                end else begin
                    if (out_ch.stick_x !== stick_expect[0].x) begin
                        $error("stick_x mismatch: expected %0d, got %0d",
                               stick_expect[0].x, out_ch.stick_x);
                        mismatch_count++;
                    end
                    if (out_ch.stick_y !== stick_expect[0].y) begin
                        $error("stick_y mismatch: expected %0d, got %0d",
                               stick_expect[0].y, out_ch.stick_y);
                        mismatch_count++;
                    end
                    void'(stick_expect.pop_front());
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned phase_gain[7]   = '{340, 512, 3, 0, 1023, 128, 700};
        int unsigned phase_radius[7] = '{40, 255, 1, 100, 128, 20, 60};
        int unsigned phase_invert[7] = '{0, 1, 2, 3, 0, 1, 2};

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.up_level     = '0;
        in_ch.down_level   = '0;
        in_ch.left_level   = '0;
        in_ch.right_level  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.idx         = REG_AXIS_GAIN;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: rest, full scale, over range, single directions, both ways
        add_levels(0, 0, 0, 0);
        add_levels(32768, 32768, 32768, 32768);
        add_levels(65535, 65535, 65535, 65535);
        add_levels(32768, 0, 0, 0);
        add_levels(0, 32768, 0, 0);
        add_levels(0, 0, 32768, 0);
        add_levels(0, 0, 0, 32768);
        add_levels(20000, 30000, 0, 0);
        add_levels(0, 0, 30000, 500);
        add_levels(1, 1, 1, 1);
        add_levels(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        add_levels(24000, 0, 0, 65535);
        wait_drained();

        // Small deadzone with both axes swapped: on, inside and just outside the circle
        write_settings(256, 5, 3);
        add_levels(0, 0, 0, 0);
        add_levels(level_for_count(4, 256), 0, level_for_count(3, 256), 0);
        add_levels(level_for_count(5, 256), 0, level_for_count(3, 256), 0);
        add_levels(0, level_for_count(2, 256), 0, level_for_count(2, 256));
        add_levels(0, 0, level_for_count(6, 256), level_for_count(1, 256));
        add_levels(0, 0, level_for_count(1, 256), 32768);
        add_levels(level_for_count(1, 256), 32768, 0, 0);
        add_levels(0, level_for_count(5, 256), 0, 0);
        add_levels(0, 0, 0, level_for_count(6, 256));
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            if (p < 7)
                write_settings(phase_gain[p], phase_radius[p], phase_invert[p]);
            else
                write_settings($urandom_range(0, 1023), $urandom_range(0, 255),
                               $urandom_range(0, 3));
            queue_random(125);
            if (p == 1) begin
                // long output stall while input keeps coming
                @(posedge i_clk);
                rx_hold_len = 300;
            end
            wait_drained();
        end

        if (mismatch_count == 0 && stick_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
